@@ hw/rtl/dbds_pkg.sv @@
// Shared types and constants for the delta base digit symbolizer.
package dbds_pkg;

    localparam int DC_W    = 16;
    localparam int RANGE_W = 16;
    localparam int BASE_W  = 9;
    localparam int COUNT_W = 4;

    localparam logic [BASE_W-1:0] BASE_CAP = 9'd257;
    localparam logic [BASE_W-1:0] BASE_MIN = 9'd1;

    localparam logic [1:0] REG_DC_OFFSET   = 2'd0;
    localparam logic [1:0] REG_RANGE_LIMIT = 2'd1;
    localparam logic [1:0] REG_DIGIT_BASE  = 2'd2;
    localparam logic [1:0] REG_DIGIT_COUNT = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ABS   = 6'b000010,
        S_CMP   = 6'b000100,
        S_START = 6'b001000,
        S_DIV   = 6'b010000,
        S_PUT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ hw/rtl/dbds_divider.sv @@
// Bit-serial restoring divider: magnitude by radix, one quotient bit per cycle.
module dbds_divider #(
    parameter int MAG_W = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [MAG_W-1:0]            dividend,
    input  logic [dbds_pkg::BASE_W-1:0] divisor,
    output dbds_pkg::div_stat_t         stat,
    output logic [MAG_W-1:0]            quotient,
    output logic [dbds_pkg::BASE_W-1:0] remainder
);

    localparam int BIT_W = $clog2(MAG_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [BIT_W-1:0]            bit_reg;
    logic [MAG_W-1:0]            dq_reg;
    logic [dbds_pkg::BASE_W-1:0] rem_reg;

    logic [dbds_pkg::BASE_W:0]   trial;
    logic [dbds_pkg::BASE_W:0]   diff;
    logic                        fits;

    assign trial = {rem_reg, dq_reg[MAG_W-1]};
    assign fits  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= '0;
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg + 1'b1;
                if (bit_reg == BIT_W'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[MAG_W-2:0], fits};
            rem_reg <= fits ? diff[dbds_pkg::BASE_W-1:0] : trial[dbds_pkg::BASE_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/delta_base_digit_symbolizer_core.sv @@
// Top level of the delta base digit symbolizer: delta, range check and digit sequencer.
//
// One sample is taken while in_stall is low; in_stall stays high until every
// result of that sample has been handed to the output register. An escape
// is put out after the delta, magnitude and range-check steps. A coded delta
// takes the same steps, puts out a sign result first when negative, then runs
// each digit through the shared bit-serial divider, which produces one
// quotient bit per cycle over the magnitude width (16 bits at the default
// sample width). out_stall can hold the sequencer in its put state.
module delta_base_digit_symbolizer_core #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_DIGITS   = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    block_start,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [8:0]              symbol,
    output logic [SAMPLE_WIDTH:0]   escape_value,
    output logic                    escape_valid,
    output logic                    run_last
);

    localparam int DW    = ((SAMPLE_WIDTH > dbds_pkg::DC_W) ? SAMPLE_WIDTH : dbds_pkg::DC_W) + 1;
    localparam int MAG_W = DW - 1;
    localparam int DIG_W = $clog2(MAX_DIGITS + 1);
    localparam logic [DIG_W-1:0] MAX_D = DIG_W'(MAX_DIGITS);

    logic [dbds_pkg::DC_W-1:0]    dc_offset_reg;
    logic [dbds_pkg::RANGE_W-1:0] range_limit_reg;
    logic [dbds_pkg::BASE_W-1:0]  digit_base_reg;
    logic [dbds_pkg::COUNT_W-1:0] digit_count_reg;

    dbds_pkg::state_t             state_reg;
    dbds_pkg::state_t             state_next;
    logic [SAMPLE_WIDTH-1:0]      prev_reg;
    logic [DW-1:0]                delta_reg;
    logic [DW-1:0]                mag_reg;
    logic [MAG_W-1:0]             work_reg;
    logic [DIG_W-1:0]             dig_idx_reg;
    logic [dbds_pkg::BASE_W-1:0]  pend_sym_reg;
    logic                         pend_esc_reg;
    logic                         pend_last_reg;
    logic                         pend_digit_reg;

    logic                         out_valid_reg;
    logic [8:0]                   symbol_reg;
    logic [SAMPLE_WIDTH:0]        escape_value_reg;
    logic                         escape_valid_reg;
    logic                         run_last_reg;

    logic                         cfg_write;
    logic                         in_take;
    logic                         out_free;
    logic                         put_now;
    logic [dbds_pkg::BASE_W-1:0]  base_eff;
    logic [DIG_W-1:0]             cnt_eff;
    logic [DW-1:0]                cur_ext;
    logic [DW-1:0]                ref_ext;
    logic [DW-1:0]                mag_calc;
    logic                         is_escape;
    logic                         is_last_digit;

    logic                         div_start;
    dbds_pkg::div_stat_t          div_stat;
    logic [MAG_W-1:0]             div_quo;
    logic [dbds_pkg::BASE_W-1:0]  div_rem;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_offset_reg   <= '0;
            range_limit_reg <= '0;
            digit_base_reg  <= dbds_pkg::BASE_MIN;
            digit_count_reg <= dbds_pkg::COUNT_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                dbds_pkg::REG_DC_OFFSET:   dc_offset_reg   <= pwdata[dbds_pkg::DC_W-1:0];
                dbds_pkg::REG_RANGE_LIMIT: range_limit_reg <= pwdata[dbds_pkg::RANGE_W-1:0];
                dbds_pkg::REG_DIGIT_BASE:  digit_base_reg  <= pwdata[dbds_pkg::BASE_W-1:0];
                dbds_pkg::REG_DIGIT_COUNT: digit_count_reg <= pwdata[dbds_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            dbds_pkg::REG_DC_OFFSET:   prdata = {16'd0, dc_offset_reg};
            dbds_pkg::REG_RANGE_LIMIT: prdata = {16'd0, range_limit_reg};
            dbds_pkg::REG_DIGIT_BASE:  prdata = {23'd0, digit_base_reg};
            dbds_pkg::REG_DIGIT_COUNT: prdata = {28'd0, digit_count_reg};
            default:                   prdata = '0;
        endcase
    end

    // Effective radix and digit count
    always_comb
    begin
        if (digit_base_reg == '0)
            base_eff = dbds_pkg::BASE_MIN;
        else if (digit_base_reg > dbds_pkg::BASE_CAP)
            base_eff = dbds_pkg::BASE_CAP;
        else
            base_eff = digit_base_reg;

        if (digit_count_reg == '0)
            cnt_eff = DIG_W'(1);
        else if (32'(digit_count_reg) > MAX_DIGITS)
            cnt_eff = MAX_D;
        else
            cnt_eff = DIG_W'(digit_count_reg);
    end

    // Datapath
    assign cur_ext  = {{(DW-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
    assign ref_ext  = block_start
                    ? {{(DW-dbds_pkg::DC_W){dc_offset_reg[dbds_pkg::DC_W-1]}}, dc_offset_reg}
                    : {{(DW-SAMPLE_WIDTH){prev_reg[SAMPLE_WIDTH-1]}}, prev_reg};
    assign mag_calc = delta_reg[DW-1] ? (~delta_reg + 1'b1) : delta_reg;
    assign is_escape = mag_reg > {{(DW-dbds_pkg::RANGE_W){1'b0}}, range_limit_reg};
    assign is_last_digit = dig_idx_reg == (cnt_eff - 1'b1);

    assign in_take   = in_valid && (state_reg == dbds_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign put_now   = (state_reg == dbds_pkg::S_PUT) && out_free;
    assign div_start = state_reg == dbds_pkg::S_START;

    dbds_divider #(
        .MAG_W (MAG_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (work_reg),
        .divisor   (base_eff),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dbds_pkg::S_IDLE:  if (in_valid) state_next = dbds_pkg::S_ABS;
            dbds_pkg::S_ABS:   state_next = dbds_pkg::S_CMP;
            dbds_pkg::S_CMP:
                if (is_escape || delta_reg[DW-1])
                    state_next = dbds_pkg::S_PUT;
                else
                    state_next = dbds_pkg::S_START;
            dbds_pkg::S_START: state_next = dbds_pkg::S_DIV;
            dbds_pkg::S_DIV:   if (div_stat.done) state_next = dbds_pkg::S_PUT;
            dbds_pkg::S_PUT:
                if (out_free)
                    state_next = pend_last_reg ? dbds_pkg::S_IDLE : dbds_pkg::S_START;
            default:           state_next = dbds_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dbds_pkg::S_IDLE;
            prev_reg    <= '0;
            dig_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_take)
            begin
                prev_reg    <= sample;
                dig_idx_reg <= '0;
            end
            else if (put_now && pend_digit_reg)
                dig_idx_reg <= dig_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            delta_reg <= cur_ext - ref_ext;
        if (state_reg == dbds_pkg::S_ABS)
            mag_reg <= mag_calc;
        if (state_reg == dbds_pkg::S_CMP)
        begin
            work_reg       <= mag_reg[MAG_W-1:0];
            pend_digit_reg <= 1'b0;
            if (is_escape)
            begin
                pend_sym_reg  <= base_eff;
                pend_esc_reg  <= 1'b1;
                pend_last_reg <= 1'b1;
            end
            else
            begin
                pend_sym_reg  <= base_eff + 1'b1;
                pend_esc_reg  <= 1'b0;
                pend_last_reg <= 1'b0;
            end
        end
        else if (state_reg == dbds_pkg::S_DIV && div_stat.done)
        begin
            work_reg       <= div_quo;
            pend_sym_reg   <= div_rem;
            pend_esc_reg   <= 1'b0;
            pend_last_reg  <= is_last_digit;
            pend_digit_reg <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (put_now)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (put_now)
        begin
            symbol_reg       <= pend_sym_reg;
            escape_value_reg <= pend_esc_reg ? delta_reg[SAMPLE_WIDTH:0] : '0;
            escape_valid_reg <= pend_esc_reg;
            run_last_reg     <= pend_last_reg;
        end
    end

    assign in_stall     = state_reg != dbds_pkg::S_IDLE;
    assign out_valid    = out_valid_reg;
    assign symbol       = symbol_reg;
    assign escape_value = escape_value_reg;
    assign escape_valid = escape_valid_reg;
    assign run_last     = run_last_reg;

    a_escape_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && escape_valid |-> run_last)
        else $error("escape result not flagged as last");

    a_plain_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !escape_valid |-> escape_value == '0)
        else $error("escape value set on a digit or sign result");

    a_digit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !escape_valid && symbol != 9'(base_eff + 1'b1) |-> symbol < base_eff)
        else $error("digit not below radix");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_put_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dbds_pkg::S_DIV && div_stat.done |=> state_reg == dbds_pkg::S_PUT)
        else $error("digit lost after divide");

endmodule
